### sv/rsf_pkg.sv
// rsf_pkg: shared widths, register indexes, reset values, lane and force result
// types and sign clamp for the rope spring force vector unit; no dependencies
`timescale 1ns / 1ps

package rsf_pkg;

    localparam int POS_W    = 20;                 // q4.16 position component
    localparam int REST_W   = 20;                 // q4.16 rest length
    localparam int SPRING_W = 24;                 // q8.16 stiffness
    localparam int FORCE_W  = 29;                 // q13.16 force component
    localparam int SQ_W     = 2 * POS_W;          // square of one magnitude
    localparam int SUM_W    = SQ_W;               // three squares stay below 2^40
    localparam int LEN_W    = SUM_W / 2;          // integer root width
    localparam int SCALE_W  = SPRING_W + LEN_W;   // k * extension
    localparam int HALF_W   = SCALE_W / 2;        // partial product split
    localparam int PROD_W   = POS_W + SCALE_W;    // magnitude * scale
    localparam int NUM_W    = PROD_W - 16;        // after the q16 shift
    localparam int QUO_W    = FORCE_W - 1;        // quotient always below 2^28
    localparam int ROOT_STG = LEN_W;              // one root bit per stage
    localparam int LANE_STG = QUO_W + 2;          // two multiply stages + divide
    localparam int CFG_DW   = 24;
    localparam int IN_DW    = 64;
    localparam int OUT_DW   = 88;

    localparam logic [REST_W-1:0]   REST_RESET   = REST_W'(19661);
    localparam logic [SPRING_W-1:0] SPRING_RESET = SPRING_W'(6554);
    localparam logic [FORCE_W-1:0]  IDLE_MARKER  = FORCE_W'(7);
    localparam logic [FORCE_W-1:0]  FORCE_POS_MAX = {1'b0, {(FORCE_W-1){1'b1}}};

    typedef enum logic [1:0] {
        CFG_REST   = 2'd0,
        CFG_SPRING = 2'd1,
        CFG_ENABLE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [QUO_W-1:0] q;
        logic             neg;
    } t_lane_out;

    typedef struct packed {
        logic [FORCE_W-1:0] force_v;
        logic               sat;
    } t_force_res;

    // sign and clamp one magnitude into a q13.16 component
    function automatic t_force_res apply_sign(input t_lane_out r);
        t_force_res res;
        logic [FORCE_W-1:0] mag;
        mag = {1'b0, r.q};
        res.sat = 1'b0;
        if (r.neg) begin
            res.force_v = FORCE_W'(~mag + 1'b1);
        end else if (mag > FORCE_POS_MAX) begin
            res.force_v = FORCE_POS_MAX;
            res.sat = 1'b1;
        end else begin
            res.force_v = mag;
        end
        return res;
    endfunction

endpackage

### sv/rsf_isqrt.sv
// rsf_isqrt: pipelined restoring integer square root, one root bit per stage
// depends on rsf_pkg
`timescale 1ns / 1ps

module rsf_isqrt (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [rsf_pkg::SUM_W-1:0]  i_sum,
    output logic [rsf_pkg::LEN_W-1:0]  o_root
);
    import rsf_pkg::*;

    localparam int REM_W = LEN_W + 2;

    logic [REM_W-1:0] r_rem  [ROOT_STG];
    logic [LEN_W-1:0] r_root [ROOT_STG];
    logic [SUM_W-1:0] r_v    [ROOT_STG];
    logic [REM_W-1:0] n_rem  [ROOT_STG];
    logic [LEN_W-1:0] n_root [ROOT_STG];
    logic [SUM_W-1:0] n_v    [ROOT_STG];

    always_comb begin
        for (int s = 0; s < ROOT_STG; s++) begin
            logic [REM_W-1:0] rem_in;
            logic [LEN_W-1:0] root_in;
            logic [SUM_W-1:0] v_in;
            logic [REM_W+1:0] sh;
            logic [REM_W+1:0] trial;
            if (s == 0) begin
                rem_in  = '0;
                root_in = '0;
                v_in    = i_sum;
            end else begin
                rem_in  = r_rem[s-1];
                root_in = r_root[s-1];
                v_in    = r_v[s-1];
            end
            sh    = {rem_in, v_in[SUM_W-1 -: 2]};
            trial = {2'b00, root_in, 2'b01};
            if (sh >= trial) begin
                n_rem[s]  = REM_W'(sh - trial);
                n_root[s] = {root_in[LEN_W-2:0], 1'b1};
            end else begin
                n_rem[s]  = REM_W'(sh);
                n_root[s] = {root_in[LEN_W-2:0], 1'b0};
            end
            n_v[s] = {v_in[SUM_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < ROOT_STG; s++) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_v[s]    <= n_v[s];
            end
        end
    end

    assign o_root = r_root[ROOT_STG-1];

endmodule

### sv/rsf_lane.sv
// rsf_lane: one force component: split multiply then pipelined long division
// depends on rsf_pkg
`timescale 1ns / 1ps

module rsf_lane (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [rsf_pkg::POS_W-1:0]    i_mag,
    input  logic                         i_neg,
    input  logic [rsf_pkg::SCALE_W-1:0]  i_scale,
    input  logic [rsf_pkg::LEN_W-1:0]    i_len,
    output rsf_pkg::t_lane_out           o_res
);
    import rsf_pkg::*;

    localparam int PP_W = POS_W + HALF_W;

    // partial products
    logic [PP_W-1:0]  r_p_lo;
    logic [PP_W-1:0]  r_p_hi;
    logic [LEN_W-1:0] r_len_b;
    logic             r_neg_b;
    // shifted numerator
    logic [NUM_W-1:0] r_num;
    logic [LEN_W-1:0] r_len_c;
    logic             r_neg_c;
    logic [PROD_W-1:0] n_prod;

    logic [LEN_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_low [QUO_W];
    logic [QUO_W-1:0] r_q   [QUO_W];
    logic [LEN_W-1:0] r_div [QUO_W];
    logic             r_sgn [QUO_W];
    logic [LEN_W-1:0] n_rem [QUO_W];
    logic [QUO_W-1:0] n_low [QUO_W];
    logic [QUO_W-1:0] n_q   [QUO_W];

    assign n_prod = PROD_W'(r_p_lo) + {r_p_hi, {HALF_W{1'b0}}};

    always_comb begin
        for (int s = 0; s < QUO_W; s++) begin
            logic [LEN_W-1:0] rem_in;
            logic [QUO_W-1:0] low_in;
            logic [QUO_W-1:0] q_in;
            logic [LEN_W-1:0] dv;
            logic [LEN_W:0]   t;
            if (s == 0) begin
                rem_in = r_num[NUM_W-1 -: LEN_W];
                low_in = r_num[QUO_W-1:0];
                q_in   = '0;
                dv     = r_len_c;
            end else begin
                rem_in = r_rem[s-1];
                low_in = r_low[s-1];
                q_in   = r_q[s-1];
                dv     = r_div[s-1];
            end
            t = {rem_in, low_in[QUO_W-1]};
            if (t >= {1'b0, dv}) begin
                n_rem[s] = LEN_W'(t - {1'b0, dv});
                n_q[s]   = {q_in[QUO_W-2:0], 1'b1};
            end else begin
                n_rem[s] = LEN_W'(t);
                n_q[s]   = {q_in[QUO_W-2:0], 1'b0};
            end
            n_low[s] = {low_in[QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_lo  <= i_mag * i_scale[HALF_W-1:0];
            r_p_hi  <= i_mag * i_scale[SCALE_W-1:HALF_W];
            r_len_b <= i_len;
            r_neg_b <= i_neg;
            r_num   <= n_prod[PROD_W-1:16];
            r_len_c <= r_len_b;
            r_neg_c <= r_neg_b;
            for (int s = 0; s < QUO_W; s++) begin
                r_rem[s] <= n_rem[s];
                r_low[s] <= n_low[s];
                r_q[s]   <= n_q[s];
                r_div[s] <= (s == 0) ? r_len_c : r_div[s-1];
                r_sgn[s] <= (s == 0) ? r_neg_c : r_sgn[s-1];
            end
        end
    end

    assign o_res.q   = r_q[QUO_W-1];
    assign o_res.neg = r_sgn[QUO_W-1];

endmodule

### sv/rope_spring_force_vector_unit.sv
// rope_spring_force_vector_unit: top level: input magnitudes, squares, root,
// spring scale, three component lanes and a two-entry output queue
// depends on rsf_pkg, rsf_isqrt, rsf_lane
`timescale 1ns / 1ps

// throughput: one point per cycle unless a full output queue stalls the pipe;
//   20-stage root and 28-stage dividers are fully pipelined, one bit per stage
// a result waiting at the output does not block input until the queue holds two
// reset (synchronous, active low) clears pipeline valids, the output queue and
//   loads rest length, spring constant and enable with their reset values
module rope_spring_force_vector_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [rsf_pkg::CFG_DW-1:0]    i_cfg_data,
    // input stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata from bit 0: pos_x[19:0], pos_y[39:20], pos_z[59:40], zero pad
    input  logic [rsf_pkg::IN_DW-1:0]     i_s_axis_tdata,
    // output stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // tdata from bit 0: force_x[28:0], force_y[57:29], force_z[86:58], zero pad
    output logic [rsf_pkg::OUT_DW-1:0]    o_m_axis_tdata,
    // tuser: saturated
    output logic                          o_m_axis_tuser
);
    import rsf_pkg::*;

    localparam int DLY   = ROOT_STG + 2;           // mag delay up to root output
    localparam int NSTG  = DLY + 2 + LANE_STG;     // total pipeline registers

    // config registers
    logic [REST_W-1:0]   r_rest;
    logic [SPRING_W-1:0] r_spring;
    logic                r_sim_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest   <= REST_RESET;
            r_spring <= SPRING_RESET;
            r_sim_en <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_REST:   r_rest   <= i_cfg_data[REST_W-1:0];
                CFG_SPRING: r_spring <= i_cfg_data[SPRING_W-1:0];
                CFG_ENABLE: r_sim_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline control: whole pipe advances together
    logic            w_en;
    logic            w_accept;
    logic            w_push;
    logic            w_pop;
    logic [1:0]      r_cnt;
    logic [NSTG-1:0] r_vld;

    assign w_pop    = o_m_axis_tvalid && i_m_axis_tready;
    assign w_en     = !r_vld[NSTG-1] || (r_cnt != 2'd2) || w_pop;
    assign w_accept = i_s_axis_tvalid && w_en;
    assign w_push   = w_en && r_vld[NSTG-1];
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], w_accept};
        end
    end

    // stage 1: magnitudes and signs of the three components
    logic [POS_W-1:0] w_pos [3];
    logic [POS_W-1:0] r_mag [3];
    logic             r_neg [3];
    logic [SQ_W-1:0]  r_sq  [3];
    logic [SUM_W-1:0] r_sum;
    logic [POS_W-1:0] r_dmag [DLY][3];
    logic             r_dneg [DLY][3];

    assign w_pos[0] = i_s_axis_tdata[POS_W-1:0];
    assign w_pos[1] = i_s_axis_tdata[2*POS_W-1:POS_W];
    assign w_pos[2] = i_s_axis_tdata[3*POS_W-1:2*POS_W];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_mag[c] <= w_pos[c][POS_W-1] ? POS_W'(~w_pos[c] + 1'b1) : w_pos[c];
                r_neg[c] <= w_pos[c][POS_W-1];
                // stage 2: squares
                r_sq[c]  <= r_mag[c] * r_mag[c];
                // magnitude delay line alongside squares, sum and root
                r_dmag[0][c] <= r_mag[c];
                r_dneg[0][c] <= r_neg[c];
                for (int d = 1; d < DLY; d++) begin
                    r_dmag[d][c] <= r_dmag[d-1][c];
                    r_dneg[d][c] <= r_dneg[d-1][c];
                end
            end
            // stage 3: sum of squares
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    // length
    logic [LEN_W-1:0] w_len;

    rsf_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_sum  (r_sum),
        .o_root (w_len)
    );

    // spring scale; untensioned points get zero scale and a unit divisor
    logic [SCALE_W-1:0] r_scale;
    logic [LEN_W-1:0]   r_div;
    logic [POS_W-1:0]   r_amag [3];
    logic               r_aneg [3];
    logic               w_tens;
    logic [LEN_W-1:0]   w_ext;

    assign w_tens = w_len > LEN_W'(r_rest);
    assign w_ext  = w_len - LEN_W'(r_rest);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_scale <= w_tens ? r_spring * w_ext : '0;
            r_div   <= w_tens ? w_len : LEN_W'(1);
            for (int c = 0; c < 3; c++) begin
                r_amag[c] <= r_dmag[DLY-1][c];
                r_aneg[c] <= r_dneg[DLY-1][c];
            end
        end
    end

    // three component lanes
    t_lane_out  w_lane [3];
    t_force_res w_frc  [3];

    for (genvar g = 0; g < 3; g++) begin : g_lane
        rsf_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_mag   (r_amag[g]),
            .i_neg   (r_aneg[g]),
            .i_scale (r_scale),
            .i_len   (r_div),
            .o_res   (w_lane[g])
        );
        assign w_frc[g] = apply_sign(w_lane[g]);
    end

    // merge lanes; idle marker when the simulation is off
    logic [OUT_DW-1:0] w_data;
    logic              w_sat;

    always_comb begin
        if (r_sim_en) begin
            w_data = {1'b0, w_frc[2].force_v, w_frc[1].force_v, w_frc[0].force_v};
            w_sat  = w_frc[0].sat || w_frc[1].sat || w_frc[2].sat;
        end else begin
            w_data = {1'b0, IDLE_MARKER, IDLE_MARKER, IDLE_MARKER};
            w_sat  = 1'b0;
        end
    end

    // two-entry output queue
    logic [OUT_DW-1:0] r_qdata [2];
    logic              r_quser [2];
    logic              r_wptr;
    logic              r_rptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_qdata[r_wptr] <= w_data;
            r_quser[r_wptr] <= w_sat;
        end
    end

    assign o_m_axis_tvalid = r_cnt != 2'd0;
    assign o_m_axis_tdata  = r_qdata[r_rptr];
    assign o_m_axis_tuser  = r_quser[r_rptr];

    // queue never overfills
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("output queue count out of range");

    // input stalls only with a full queue and a finished result behind it
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_vld[NSTG-1] && r_cnt == 2'd2))
        else $error("input stalled without cause");

    // the 28-bit quotient always fits the positive range, so no clamp can occur
    a_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_m_axis_tuser) else $error("unexpected saturation");

endmodule
